/* design/pixel_format_converter_top_defines.svh */
// assertion macros for the pixel format converter
`ifndef PIXEL_FORMAT_CONVERTER_TOP_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_TOP_DEFINES_SVH

// next-cycle implication, ignored while in reset
`define PFC_ASSERT_NEXT(label, cond, expect_next) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error("pfc port check failed");

// state right after a reset cycle
`define PFC_ASSERT_AFTER_RESET(label, expect_next) \
  label: assert property (@(posedge clk) !rst_n |=> (expect_next)) \
    else $error("pfc reset check failed");

`endif

/* design/pfc_pkg.sv */
`timescale 1ns / 1ps
package pfc_pkg;

  typedef enum logic [2:0] {
    SRC_ARGB8888,
    SRC_RGB888,
    SRC_RGB555,
    SRC_RGB565,
    SRC_ARGB4444,
    SRC_INDEX8,
    SRC_INDEX4,
    SRC_INDEX1
  } src_fmt_t;

  typedef enum logic [2:0] {
    DST_ARGB8888,
    DST_RGB888,
    DST_RGB555,
    DST_RGB565,
    DST_ARGB4444
  } dst_fmt_t;

  typedef enum logic {
    DIR_EXPAND,
    DIR_PACK
  } dir_t;

  typedef enum logic {
    REQ_PIXEL,
    REQ_PAL_WRITE
  } req_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_FORMAT   = 2'd2;

  typedef struct packed {
    dir_t     direction;
    src_fmt_t source_format;
    dst_fmt_t dest_format;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_DIRECT,
    CMD_PALETTE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    PAL_MODE8,
    PAL_MODE4,
    PAL_MODE1
  } pal_mode_t;

  typedef struct packed {
    cmd_kind_t   kind;
    pal_mode_t   mode;
    logic [3:0]  count;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } result_t;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

endpackage

/* design/pfc_front.sv */
`timescale 1ns / 1ps
module pfc_front (
  input  pfc_pkg::cfg_t cfg,
  input  logic          in_push,
  input  logic          in_req_type,
  input  logic [31:0]   in_pixel_word,
  input  logic [3:0]    in_valid_pixels,
  input  logic [7:0]    in_pal_index,
  input  logic [23:0]   in_pal_color,
  output logic          in_full,
  input  logic          q_full,
  output logic          q_push,
  output pfc_pkg::cmd_t q_cmd
);

  logic [31:0] w;

  assign w = in_pixel_word;

  always_comb begin
    q_cmd.kind  = pfc_pkg::CMD_DIRECT;
    q_cmd.mode  = pfc_pkg::PAL_MODE8;
    q_cmd.count = 4'd1;
    q_cmd.data  = 32'h0;
    if (pfc_pkg::req_t'(in_req_type) == pfc_pkg::REQ_PAL_WRITE) begin
      q_cmd.kind  = pfc_pkg::CMD_WRITE;
      q_cmd.count = 4'd0;
      q_cmd.data  = {in_pal_index, in_pal_color};
    end else if (cfg.direction == pfc_pkg::DIR_PACK) begin
      case (cfg.dest_format)
        pfc_pkg::DST_ARGB8888: q_cmd.data = w;
        pfc_pkg::DST_RGB888:   q_cmd.data = {8'h0, w[23:0]};
        pfc_pkg::DST_RGB555:   q_cmd.data = {17'h0, w[23:19], w[15:11], w[7:3]};
        pfc_pkg::DST_RGB565:   q_cmd.data = {16'h0, w[23:19], w[15:10], w[7:3]};
        pfc_pkg::DST_ARGB4444: q_cmd.data = {16'h0, w[31:28], w[23:20], w[15:12], w[7:4]};
        default:               q_cmd.data = 32'h0;
      endcase
    end else begin
      unique case (cfg.source_format)
        pfc_pkg::SRC_ARGB8888: q_cmd.data = w;
        pfc_pkg::SRC_RGB888:   q_cmd.data = {8'h0, w[23:0]};
        pfc_pkg::SRC_RGB555: begin
          q_cmd.data = {8'h0, w[14:10], 3'b0, w[9:5], 3'b0, w[4:0], 3'b0};
        end
        pfc_pkg::SRC_RGB565: begin
          q_cmd.data = {8'h0, w[15:11], 3'b0, w[10:5], 2'b0, w[4:0], 3'b0};
        end
        pfc_pkg::SRC_ARGB4444: begin
          q_cmd.data = {w[15:12], 4'b0, w[11:8], 4'b0, w[7:4], 4'b0, w[3:0], 4'b0};
        end
        pfc_pkg::SRC_INDEX8: begin
          q_cmd.kind = pfc_pkg::CMD_PALETTE;
          q_cmd.mode = pfc_pkg::PAL_MODE8;
          q_cmd.data = {24'h0, w[7:0]};
        end
        pfc_pkg::SRC_INDEX4: begin
          q_cmd.kind  = pfc_pkg::CMD_PALETTE;
          q_cmd.mode  = pfc_pkg::PAL_MODE4;
          q_cmd.count = (in_valid_pixels > 4'd2) ? 4'd2 : in_valid_pixels;
          q_cmd.data  = {24'h0, w[7:0]};
        end
        pfc_pkg::SRC_INDEX1: begin
          q_cmd.kind  = pfc_pkg::CMD_PALETTE;
          q_cmd.mode  = pfc_pkg::PAL_MODE1;
          q_cmd.count = (in_valid_pixels > 4'd8) ? 4'd8 : in_valid_pixels;
          q_cmd.data  = {24'h0, w[7:0]};
        end
        default: q_cmd.data = w;
      endcase
    end
  end

  // an index byte with no valid pixels is taken and dropped
  assign q_push  = in_push && !q_full &&
                   !(q_cmd.kind == pfc_pkg::CMD_PALETTE && q_cmd.count == 4'd0);
  assign in_full = q_full;

endmodule

/* design/pfc_cmd_queue.sv */
`timescale 1ns / 1ps
module pfc_cmd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pfc_pkg::cmd_t    cmd,
  output logic             full,
  input  logic             pop,
  output pfc_pkg::q_head_t head
);

  localparam int PTR_W = $clog2(pfc_pkg::CMD_DEPTH);
  localparam int CNT_W = $clog2(pfc_pkg::CMD_DEPTH + 1);

  pfc_pkg::cmd_t q_mem_r [pfc_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full       = cnt_r == CNT_W'(pfc_pkg::CMD_DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.cmd   = q_mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

/* design/pfc_back.sv */
`timescale 1ns / 1ps
module pfc_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pfc_pkg::q_head_t head,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [31:0]      out_pixel_out,
  output logic             out_last
);

  localparam int AW        = $clog2(PALETTE_DEPTH);
  localparam int OPTR_W    = $clog2(pfc_pkg::OUT_DEPTH);
  localparam int OCNT_W    = $clog2(pfc_pkg::OUT_DEPTH + 1);
  localparam int CREDIT_W  = OCNT_W + 1;

  logic [23:0]       pal_mem_r [PALETTE_DEPTH];
  logic [23:0]       rd_data_r;

  logic [2:0]        k_r, k_nxt;
  logic [7:0]        byte_in;
  logic [7:0]        rd_idx;
  logic [7:0]        wr_idx;
  logic              is_last;
  logic              go;
  logic              issue;
  logic              pal_we;
  logic              issue_ok;
  logic              rd_in_range;

  logic              s1_valid_r;
  logic              s1_last_r;
  logic              s1_pal_r;
  logic              s1_in_range_r;
  logic [31:0]       s1_data_r;
  pfc_pkg::result_t  s1_result;

  pfc_pkg::result_t  out_mem_r [pfc_pkg::OUT_DEPTH];
  logic [OPTR_W-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [OPTR_W-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              out_do_pop;

  assign byte_in = head.cmd.data[7:0];
  assign wr_idx  = head.cmd.data[31:24];

  always_comb begin
    case (head.cmd.mode)
      pfc_pkg::PAL_MODE8: rd_idx = byte_in;
      pfc_pkg::PAL_MODE4: rd_idx = (k_r == 3'd0) ? {4'h0, byte_in[7:4]} : {4'h0, byte_in[3:0]};
      pfc_pkg::PAL_MODE1: rd_idx = {7'h0, byte_in[3'd7 - k_r]};
      default:            rd_idx = byte_in;
    endcase
  end

  assign issue_ok = ({1'b0, ocnt_r} + CREDIT_W'(s1_valid_r)) < CREDIT_W'(pfc_pkg::OUT_DEPTH);
  assign is_last  = (head.cmd.kind != pfc_pkg::CMD_PALETTE) ||
                    ({1'b0, k_r} == head.cmd.count - 4'd1);
  assign go       = head.valid && (head.cmd.kind == pfc_pkg::CMD_WRITE || issue_ok);
  assign issue    = go && head.cmd.kind != pfc_pkg::CMD_WRITE;
  assign q_pop    = go && is_last;
  assign pal_we   = go && head.cmd.kind == pfc_pkg::CMD_WRITE &&
                    ({1'b0, wr_idx} < 9'(PALETTE_DEPTH));
  assign rd_in_range = {1'b0, rd_idx} < 9'(PALETTE_DEPTH);

  always_comb begin
    k_nxt = k_r;
    if (go) begin
      k_nxt = is_last ? 3'd0 : k_r + 3'd1;
    end
  end

  // palette
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem_r[wr_idx[AW-1:0]] <= head.cmd.data[23:0];
    end
    if (issue) begin
      rd_data_r <= pal_mem_r[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= 3'd0;
      s1_valid_r <= 1'b0;
    end else begin
      k_r        <= k_nxt;
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_last_r     <= is_last;
      s1_pal_r      <= head.cmd.kind == pfc_pkg::CMD_PALETTE;
      s1_in_range_r <= rd_in_range;
      s1_data_r     <= head.cmd.data;
    end
  end

  always_comb begin
    s1_result.last  = s1_last_r;
    s1_result.pixel = s1_data_r;
    if (s1_pal_r) begin
      s1_result.pixel = s1_in_range_r ? {8'h0, rd_data_r} : 32'h0;
    end
  end

  // result buffer
  assign out_empty  = ocnt_r == '0;
  assign out_do_pop = out_pop && !out_empty;

  always_comb begin
    owr_ptr_nxt = s1_valid_r ? owr_ptr_r + 1'b1 : owr_ptr_r;
    ord_ptr_nxt = out_do_pop ? ord_ptr_r + 1'b1 : ord_ptr_r;
    ocnt_nxt    = ocnt_r + OCNT_W'(s1_valid_r) - OCNT_W'(out_do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_mem_r[owr_ptr_r] <= s1_result;
    end
  end

  assign out_pixel_out = out_mem_r[ord_ptr_r].pixel;
  assign out_last      = out_mem_r[ord_ptr_r].last;

endmodule

/* design/pixel_format_converter_top.sv */
`timescale 1ns / 1ps
// throughput: one input transaction per cycle unless in_full; an index byte yields
//   one result per cycle while the out buffer has room, up to 8 for index1 and 2 for index4
// path to the out_ ports: command queue, palette read stage, result buffer
// reset: synchronous active low rst_n clears config registers, queues and counters;
//   palette contents stay undefined until written, no clearing pass
module pixel_format_converter_top #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic [31:0]                    in_pixel_word,
  input  logic [3:0]                     in_valid_pixels,
  input  logic [7:0]                     in_pal_index,
  input  logic [23:0]                    in_pal_color,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [31:0]                    out_pixel_out,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pfc_pkg::cfg_t    cfg_r, cfg_nxt;
  pfc_pkg::cmd_t    q_cmd;
  pfc_pkg::q_head_t q_head;
  logic             q_push;
  logic             q_full;
  logic             q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::REG_DIRECTION:     cfg_nxt.direction     = pfc_pkg::dir_t'(cfg_wdata[0]);
        pfc_pkg::REG_SOURCE_FORMAT: cfg_nxt.source_format = pfc_pkg::src_fmt_t'(cfg_wdata);
        pfc_pkg::REG_DEST_FORMAT:   cfg_nxt.dest_format   = pfc_pkg::dst_fmt_t'(cfg_wdata);
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction     <= pfc_pkg::DIR_EXPAND;
      cfg_r.source_format <= pfc_pkg::SRC_ARGB8888;
      cfg_r.dest_format   <= pfc_pkg::DST_ARGB8888;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfc_front u_front (
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_req_type     (in_req_type),
    .in_pixel_word   (in_pixel_word),
    .in_valid_pixels (in_valid_pixels),
    .in_pal_index    (in_pal_index),
    .in_pal_color    (in_pal_color),
    .in_full         (in_full),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  pfc_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .cmd   (q_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head)
  );

  pfc_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel_out (out_pixel_out),
    .out_last      (out_last)
  );

endmodule

/* design/pfc_checker.sv */
`timescale 1ns / 1ps
`include "pixel_format_converter_top_defines.svh"
module pfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_pixel_out,
  input logic        out_last
);

  `PFC_ASSERT_AFTER_RESET(a_empty_after_reset, out_empty && !in_full)
  // a waiting result is held until taken
  `PFC_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty && $stable(out_pixel_out) && $stable(out_last))
  // the input side only fills up through an accepted transaction
  `PFC_ASSERT_NEXT(a_full_needs_push, !in_full && !in_push, !in_full)
  // results only leave through an accepted transaction
  `PFC_ASSERT_NEXT(a_no_lost_result, !out_empty && !out_pop, !out_empty)

endmodule

bind pixel_format_converter_top pfc_checker u_pfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_pixel_out (out_pixel_out),
  .out_last      (out_last)
);

/* tb/sv/tb_pixel_format_converter_top.sv */
`timescale 1ns / 1ps
module tb_pixel_format_converter_top;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 285;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  logic                           in_full;
  logic                           in_req_type = pfc_pkg::REQ_PIXEL;
  logic [31:0]                    in_pixel_word = '0;
  logic [3:0]                     in_valid_pixels = '0;
  logic [7:0]                     in_pal_index = '0;
  logic [23:0]                    in_pal_color = '0;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic [31:0]                    out_pixel_out;
  logic                           out_last;
  logic                           cfg_we = 1'b0;
  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the block's registers and palette
  pfc_pkg::dir_t     mode_dir = pfc_pkg::DIR_EXPAND;
  pfc_pkg::src_fmt_t mode_src = pfc_pkg::SRC_ARGB8888;
  logic [2:0]        mode_dst = pfc_pkg::DST_ARGB8888;
  logic [23:0]       pal_shadow [256];
  bit                pal_written [256];
  logic [7:0]        written_entries [$];

  pfc_pkg::result_t  pending_pixels [$];
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                no_idle = 1'b0;
  int                hold_cycles = 0;
  int                pop_wait = 0;

  pixel_format_converter_top #(.PALETTE_DEPTH(256)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_req_type(in_req_type), .in_pixel_word(in_pixel_word),
    .in_valid_pixels(in_valid_pixels), .in_pal_index(in_pal_index),
    .in_pal_color(in_pal_color),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_pixel_out(out_pixel_out), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_pixel_format_converter_top NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] palette_color(input logic [7:0] ix);
    return {8'h00, pal_shadow[ix]};
  endfunction

  function automatic logic [31:0] expand_pixel(input logic [31:0] w);
    case (mode_src)
      pfc_pkg::SRC_ARGB8888: return w;
      pfc_pkg::SRC_RGB888:   return {8'h00, w[23:0]};
      pfc_pkg::SRC_RGB555:   return {8'h00, w[14:10], 3'b0, w[9:5], 3'b0, w[4:0], 3'b0};
      pfc_pkg::SRC_RGB565:   return {8'h00, w[15:11], 3'b0, w[10:5], 2'b0, w[4:0], 3'b0};
      pfc_pkg::SRC_ARGB4444: begin
        return {w[15:12], 4'b0, w[11:8], 4'b0, w[7:4], 4'b0, w[3:0], 4'b0};
      end
      default:               return palette_color(w[7:0]);
    endcase
  endfunction

  function automatic logic [31:0] pack_pixel(input logic [31:0] c);
    case (mode_dst)
      pfc_pkg::DST_ARGB8888: return c;
      pfc_pkg::DST_RGB888:   return {8'h00, c[23:0]};
      pfc_pkg::DST_RGB555:   return {17'b0, c[23:19], c[15:11], c[7:3]};
      pfc_pkg::DST_RGB565:   return {16'b0, c[23:19], c[15:10], c[7:3]};
      pfc_pkg::DST_ARGB4444: return {16'b0, c[31:28], c[23:20], c[15:12], c[7:4]};
      default:               return 32'h0;
    endcase
  endfunction

  function automatic void predict_pixels(input logic req, input logic [31:0] word,
                                         input logic [3:0] valid, input logic [7:0] pidx,
                                         input logic [23:0] pcol);
    pfc_pkg::result_t r;
    int               n;
    logic [7:0]       ix;
    if (req == pfc_pkg::REQ_PAL_WRITE) begin
      pal_shadow[pidx] = pcol;
      if (!pal_written[pidx]) begin
        pal_written[pidx] = 1'b1;
        written_entries.push_back(pidx);
      end
      return;
    end
    if (mode_dir == pfc_pkg::DIR_PACK) begin
      r.pixel = pack_pixel(word);
      r.last  = 1'b1;
      pending_pixels.push_back(r);
      return;
    end
    if (mode_src == pfc_pkg::SRC_INDEX4 || mode_src == pfc_pkg::SRC_INDEX1) begin
      if (mode_src == pfc_pkg::SRC_INDEX4) n = (valid > 4'd2) ? 2 : int'(valid);
      else n = (valid > 4'd8) ? 8 : int'(valid);
      for (int k = 0; k < n; k++) begin
        if (mode_src == pfc_pkg::SRC_INDEX4)
          ix = (k == 0) ? {4'h0, word[7:4]} : {4'h0, word[3:0]};
        else ix = {7'h00, word[7-k]};
        r.pixel = palette_color(ix);
        r.last  = (k == n - 1);
        pending_pixels.push_back(r);
      end
    end else begin
      r.pixel = expand_pixel(word);
      r.last  = 1'b1;
      pending_pixels.push_back(r);
    end
  endfunction

  task automatic check_pixel(input logic [31:0] pixel, input logic last);
    pfc_pkg::result_t want;
    if (pending_pixels.size() == 0) begin
      $error("unexpected transaction: pixel_out %h last %0b", pixel, last);
      fail_count++;
    end else begin
      want = pending_pixels.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel_out mismatch: expected %h, actual %h", want.pixel, pixel);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        check_pixel(out_pixel_out, out_last);
        pop_wait = pick_gap();
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic req, input logic [31:0] word, input logic [3:0] valid,
                           input logic [7:0] pidx, input logic [23:0] pcol);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_req_type     <= req;
    in_pixel_word   <= word;
    in_valid_pixels <= valid;
    in_pal_index    <= pidx;
    in_pal_color    <= pcol;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_pixels(req, word, valid, pidx, pcol);
  endtask

  task automatic send_pixel(input logic [31:0] word, input logic [3:0] valid);
    send_item(pfc_pkg::REQ_PIXEL, word, valid, 8'($urandom()), 24'($urandom()));
  endtask

  task automatic write_palette(input logic [7:0] pidx, input logic [23:0] pcol);
    send_item(pfc_pkg::REQ_PAL_WRITE, $urandom(), 4'($urandom()), pidx, pcol);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input pfc_pkg::dir_t d, input pfc_pkg::src_fmt_t s,
                          input logic [2:0] t);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= pfc_pkg::REG_DIRECTION;
    cfg_wdata <= {2'b00, d};
    @(posedge clk);
    cfg_index <= pfc_pkg::REG_SOURCE_FORMAT;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= pfc_pkg::REG_DEST_FORMAT;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_dir = d;
    mode_src = s;
    mode_dst = t;
  endtask

  task automatic test_palette_load();
    write_palette(8'd0, 24'hFFFFFF);
    write_palette(8'd1, 24'h000000);
    write_palette(8'd15, 24'($urandom()));
    write_palette(8'd255, 24'($urandom()));
  endtask

  task automatic test_expand_formats();
    // registers still at reset: argb8888 pass-through
    send_pixel(32'hFFFFFFFF, 4'd1);
    send_pixel(32'h00000000, 4'd1);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_RGB888, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd1);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_RGB555, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd1);
    send_pixel(32'h00007C00, 4'd0);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_RGB565, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd1);
    send_pixel(32'h000007E0, 4'd15);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_ARGB4444, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd1);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_INDEX8, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd8);
  endtask

  task automatic test_index_unpack();
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_INDEX4, pfc_pkg::DST_ARGB8888);
    send_pixel(32'h000000F0, 4'd2);
    send_pixel(32'hFFFFFF0F, 4'd15);
    send_pixel(32'h000000FF, 4'd0);
    send_pixel(32'h000000F1, 4'd1);
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_INDEX1, pfc_pkg::DST_ARGB8888);
    send_pixel(32'h00000081, 4'd8);
    send_pixel(32'hFFFFFFFF, 4'd3);
    send_pixel(32'h0000005A, 4'd15);
    send_pixel(32'h00000000, 4'd0);
  endtask

  task automatic test_pack_formats();
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_INDEX1, pfc_pkg::DST_RGB888);
    send_pixel(32'hFFFFFFFF, 4'd1);
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_ARGB8888, pfc_pkg::DST_RGB555);
    send_pixel(32'hFFFFFFFF, 4'd1);
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_ARGB8888, pfc_pkg::DST_RGB565);
    send_pixel(32'h0000FC00, 4'd1);
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_ARGB8888, pfc_pkg::DST_ARGB4444);
    send_pixel(32'hFFFFFFFF, 4'd1);
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_ARGB8888, pfc_pkg::DST_ARGB8888);
    send_pixel(32'hFFFFFFFF, 4'd0);
    set_mode(pfc_pkg::DIR_PACK, pfc_pkg::SRC_ARGB8888, 3'd7);
    send_pixel(32'hFFFFFFFF, 4'd1);
  endtask

  task automatic test_backpressure();
    bit saved;
    saved = no_idle;
    set_mode(pfc_pkg::DIR_EXPAND, pfc_pkg::SRC_INDEX1, pfc_pkg::DST_ARGB8888);
    no_idle = 1'b1;
    hold_cycles = HOLD_CYCLES;
    repeat (24) send_pixel($urandom(), 4'd8);
    // sender pause until the block has drained
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) send_pixel($urandom(), 4'($urandom_range(1, 8)));
    no_idle = saved;
  endtask

  task automatic send_random_item();
    logic [31:0] word;
    logic [3:0]  valid;
    int          roll;
    word = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 70) valid = 4'($urandom_range(1, 8));
    else if (roll < 85) valid = 4'($urandom_range(9, 15));
    else valid = 4'd0;
    if ($urandom_range(0, 99) < 15) begin
      write_palette(8'($urandom()), 24'($urandom()));
    end else begin
      if (mode_dir == pfc_pkg::DIR_EXPAND && mode_src == pfc_pkg::SRC_INDEX8)
        word[7:0] = written_entries[$urandom_range(0, written_entries.size() - 1)];
      send_pixel(word, valid);
    end
  endtask

  task automatic test_random_stream();
    int       sent;
    int       burst;
    logic [2:0] dst;
    sent = 0;
    for (int i = 0; i < 16; i++) write_palette(8'(i), 24'($urandom()));
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) dst = 3'($urandom_range(5, 7));
      else dst = 3'($urandom_range(0, 4));
      set_mode(pfc_pkg::dir_t'($urandom_range(0, 1)),
               pfc_pkg::src_fmt_t'($urandom_range(0, 7)), dst);
      no_idle = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 40);
      repeat (burst) send_random_item();
      sent += burst;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      pal_shadow[i]  = '0;
      pal_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_expand_formats();
    test_index_unpack();
    test_pack_formats();
    test_backpressure();
    test_random_stream();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_pixel_format_converter_top OK");
    end else begin
      $display("tb_pixel_format_converter_top NOT OK");
    end
    $finish;
  end

endmodule

/* pixel_format_converter_top.f */
+incdir+design
design/pfc_pkg.sv
design/pfc_front.sv
design/pfc_cmd_queue.sv
design/pfc_back.sv
design/pixel_format_converter_top.sv
design/pfc_checker.sv
tb/sv/tb_pixel_format_converter_top.sv
